@@ design/jsfsr_pkg.sv @@
// Shared types and constants of the FIFO/SJF/round-robin job scheduler.
package jsfsr_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_NEXT   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [0:0] REG_POLICY  = 1'd0;
    localparam logic [0:0] REG_QUANTUM = 1'd1;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] burst_time;
        logic [15:0] arrival_order;
    } job_t;

    typedef struct packed {
        logic [7:0]  slice_job;
        logic [15:0] slice_length;
        logic        job_finished;
        logic        schedule_done;
        logic        table_full;
    } result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture the input beat, clear scan state
        logic scan_step;   // examine entry at scan index
        logic shift_step;  // move entry idx-1 to idx (insert), walking down
        logic write_new;   // write captured job at scan position
        logic apply_next;  // charge the chosen entry, form a slice result
        logic clear;       // empty table
        logic set_full;    // form a table-full result
        logic set_zero;    // form an all-zero result
        logic set_done;    // form a schedule-done result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       scan_end;   // scan index reached the end
        logic       stop;       // scan found its stopping entry
        logic       shift_end;  // shift pointer reached insert position
        logic       found;
    } stat_t;

endpackage

@@ design/jsfsr_ctrl.sv @@
// Controller state machine of the job scheduler.
module jsfsr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  jsfsr_pkg::stat_t st,
    output jsfsr_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            res_load
);
    import jsfsr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        res_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (st.action == ACT_INSERT && st.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next = S_OUT;
                end
                else if (st.action == ACT_INSERT || st.action == ACT_NEXT)
                    state_next = S_SCAN;
                else
                begin
                    if (st.action == ACT_CLEAR)
                        cmd.clear = 1'b1;
                    cmd.set_zero = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (st.scan_end || st.stop)
                    state_next = (st.action == ACT_INSERT) ? S_SHIFT : S_FIN;
                else
                    cmd.scan_step = 1'b1;
            end
            S_SHIFT:
            begin
                if (st.shift_end)
                begin
                    cmd.write_new = 1'b1;
                    cmd.set_zero = 1'b1;
                    state_next = S_OUT;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            S_FIN:
            begin
                if (st.found)
                    cmd.apply_next = 1'b1;
                else
                    cmd.set_done = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> state_reg == S_IDLE) else $error("result load not ending item");
    a_one_fin: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.apply_next && cmd.set_done)) else $error("two results formed");
endmodule

@@ design/jsfsr_dp.sv @@
// Datapath of the job scheduler: job table, scan unit and result former.
module jsfsr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  jsfsr_pkg::cmd_t   cmd,
    input  logic [1:0]        in_action,
    input  jsfsr_pkg::job_t   in_job,
    input  logic [1:0]        policy,
    input  logic [15:0]       quantum,
    output jsfsr_pkg::stat_t  st,
    output jsfsr_pkg::result_t res
);
    import jsfsr_pkg::*;

    logic [7:0]  ids_mem [MAX_JOBS];
    logic [15:0] ord_mem [MAX_JOBS];
    logic [15:0] rem_mem [MAX_JOBS];

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] cursor_reg;
    logic [1:0]       action_reg;
    job_t             job_reg;
    logic [CNT_W-1:0] scan_reg;   // scan position, counts up
    logic [CNT_W-1:0] steps_reg;  // entries visited (round robin)
    logic [CNT_W-1:0] shp_reg;    // shift pointer, counts down
    logic [IDX_W-1:0] pick_reg;
    logic             found_reg;
    result_t          res_reg;

    logic [IDX_W-1:0] sidx, pidx;
    logic [15:0]      srem, prem, run;
    logic [CNT_W-1:0] start, wrap_next;
    logic [15:0]      q;

    assign start = ({1'b0, cursor_reg} < count_reg) ? CNT_W'(cursor_reg) : '0;
    assign sidx = scan_reg[IDX_W-1:0];
    assign srem = rem_mem[sidx];
    assign pidx = pick_reg;
    assign prem = rem_mem[pidx];
    assign q = (quantum == 16'd0) ? 16'd1 : quantum;
    assign run = (policy == POL_RR && prem > q) ? q : prem;
    assign wrap_next = (scan_reg + 1'b1 >= count_reg) ? '0 : scan_reg + 1'b1;

    always_comb
    begin
        st.action = action_reg;
        st.full = (count_reg >= CNT_W'(MAX_JOBS));
        st.found = found_reg;
        st.shift_end = (shp_reg == scan_reg);
        if (action_reg == ACT_INSERT)
        begin
            st.scan_end = (scan_reg >= count_reg);
            st.stop = !st.scan_end && !(ord_mem[sidx] < job_reg.arrival_order);
        end
        else if (policy == POL_RR)
        begin
            st.scan_end = (steps_reg >= count_reg);
            st.stop = found_reg;
        end
        else
        begin
            st.scan_end = (scan_reg >= count_reg);
            st.stop = found_reg && policy != POL_SJF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            job_reg <= in_job;
        end
        if (cmd.shift_step)
        begin
            ids_mem[shp_reg[IDX_W-1:0]] <= ids_mem[IDX_W'(shp_reg - 1'b1)];
            ord_mem[shp_reg[IDX_W-1:0]] <= ord_mem[IDX_W'(shp_reg - 1'b1)];
            rem_mem[shp_reg[IDX_W-1:0]] <= rem_mem[IDX_W'(shp_reg - 1'b1)];
        end
        if (cmd.write_new)
        begin
            ids_mem[sidx] <= job_reg.job_id;
            ord_mem[sidx] <= job_reg.arrival_order;
            rem_mem[sidx] <= job_reg.burst_time;
        end
        if (cmd.apply_next)
            rem_mem[pidx] <= prem - run;
        // Fields from the top: slice_job, slice_length, job_finished,
        // schedule_done, table_full.
        if (cmd.apply_next)
            res_reg <= {ids_mem[pidx], run, (prem == run), 1'b0, 1'b0};
        else if (cmd.set_zero || cmd.set_full || cmd.set_done)
            res_reg <= {8'd0, 16'd0, 1'b0, cmd.set_done, cmd.set_full};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cursor_reg <= '0;
            action_reg <= ACT_INSERT;
            scan_reg <= '0;
            steps_reg <= '0;
            shp_reg <= '0;
            pick_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                action_reg <= in_action;
                steps_reg <= '0;
                found_reg <= 1'b0;
                pick_reg <= '0;
                scan_reg <= (in_action == ACT_NEXT && policy == POL_RR) ? start : '0;
                shp_reg <= count_reg;
            end
            if (cmd.scan_step)
            begin
                if (action_reg != ACT_INSERT && srem != 16'd0 &&
                    (!found_reg || policy != POL_SJF || srem <= prem))
                begin
                    pick_reg <= sidx;
                    found_reg <= 1'b1;
                end
                if (action_reg == ACT_NEXT && policy == POL_RR)
                begin
                    if (srem == 16'd0)
                        scan_reg <= wrap_next;
                    steps_reg <= steps_reg + 1'b1;
                end
                else
                    scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.shift_step)
                shp_reg <= shp_reg - 1'b1;
            if (cmd.write_new)
                count_reg <= count_reg + 1'b1;
            if (cmd.apply_next && policy == POL_RR)
                cursor_reg <= ({1'b0, pidx} + 1'b1 < count_reg) ? IDX_W'(pidx + 1'b1) : '0;
            if (cmd.clear)
            begin
                count_reg <= '0;
                cursor_reg <= '0;
            end
        end
    end

    assign res = res_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS)) else $error("count past table size");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> count_reg < CNT_W'(MAX_JOBS)) else $error("write into full table");
    a_apply_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply_next |-> found_reg) else $error("slice without pick");
endmodule

@@ design/job_scheduler_fifo_sjf_rr_unit.sv @@
// Top level of the FIFO / shortest-job-first / round-robin job scheduler.
//
//  Channel  Dir  Beat contents
//  s_axis   in   tuser: action; tdata: job_id, burst_time, arrival_order
//  m_axis   out  tdata: slice_job, slice_length, job_finished, schedule_done, table_full
//  cfg      in   cfg_we, cfg_index (0 policy, 1 quantum), cfg_data
//
// One beat is handled at a time. Insert searches upward for the place, then
// shifts down one entry per cycle; next examines one table entry per cycle.
// Clear and unused actions form their result without a scan. Reset empties
// the table and sets policy FIFO and quantum 4. A stalled output holds the
// result in the output register; the input is ready again once it is there,
// and the next result waits in the block until the output register is free.
module job_scheduler_fifo_sjf_rr_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // [7:0] job_id, [23:8] burst_time, [39:24] arrival_order
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] slice_job, [23:8] slice_length, [24] job_finished,
    // [25] schedule_done, [26] table_full
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import jsfsr_pkg::*;

    logic [1:0]  policy_reg;
    logic [15:0] quantum_reg;
    cmd_t        cmd;
    stat_t       st;
    result_t     res;
    job_t        job;
    logic        busy, res_load, in_fire, out_free;
    logic        ovalid_reg;
    logic [31:0] odata_reg;

    // Configuration registers must be written only while idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIFO;
            quantum_reg <= 16'd4;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POLICY)
                policy_reg <= cfg_data[1:0];
            else
                quantum_reg <= cfg_data;
        end
    end

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    assign job.job_id = s_axis_tdata[7:0];
    assign job.burst_time = s_axis_tdata[23:8];
    assign job.arrival_order = s_axis_tdata[39:24];

    jsfsr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .st(st), .cmd(cmd), .busy(busy), .res_load(res_load)
    );

    jsfsr_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_action(s_axis_tuser),
        .in_job(job), .policy(policy_reg), .quantum(quantum_reg),
        .st(st), .res(res)
    );

    // Output register: the result beat waits here until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            odata_reg <= {5'd0, res.table_full, res.schedule_done, res.job_finished,
                          res.slice_length, res.slice_job};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the FIFO / shortest-job-first / round-robin job scheduler.
`timescale 1ns / 1ps

class slice_scoreboard;
    logic [1:0]  policy;
    logic [15:0] quantum;
    logic [7:0]  ids [jsfsr_pkg::MAX_JOBS];
    logic [15:0] orders [jsfsr_pkg::MAX_JOBS];
    logic [15:0] remaining [jsfsr_pkg::MAX_JOBS];
    int          count;
    int          cursor;
    logic [31:0] pending_slices [$];
    int          errors;

    function void reset_state();
        policy = jsfsr_pkg::POL_FIFO;
        quantum = 16'd4;
        count = 0;
        cursor = 0;
        errors = 0;
        pending_slices.delete();
    endfunction

    function void write_reg(logic [0:0] index, logic [15:0] value);
        if (index == jsfsr_pkg::REG_POLICY)
            policy = value[1:0];
        else
            quantum = value;
    endfunction

    // Works out the result of one accepted beat and updates the job table.
    function void note_beat(logic [1:0] act_in, logic [39:0] beat);
        logic [1:0]  act;
        logic [7:0]  sj;
        logic [15:0] run;
        logic [15:0] q;
        logic        fin;
        logic        done;
        logic        full;
        int          pos;
        int          pick;
        int          k;
        int          idx;
        int          start;
        bit          found;
        act = act_in;
        sj = 0;
        run = 0;
        fin = 0;
        done = 0;
        full = 0;
        found = 0;
        pick = 0;
        if (act == jsfsr_pkg::ACT_INSERT)
        begin
            if (count >= jsfsr_pkg::MAX_JOBS)
                full = 1;
            else
            begin
                pos = 0;
                while (pos < count && orders[pos] < beat[39:24])
                    pos++;
                for (k = count; k > pos; k--)
                begin
                    ids[k] = ids[k-1];
                    orders[k] = orders[k-1];
                    remaining[k] = remaining[k-1];
                end
                ids[pos] = beat[7:0];
                remaining[pos] = beat[23:8];
                orders[pos] = beat[39:24];
                count++;
            end
        end
        else if (act == jsfsr_pkg::ACT_NEXT)
        begin
            if (policy == jsfsr_pkg::POL_SJF)
            begin
                for (k = 0; k < count; k++)
                    if (remaining[k] != 0 && (!found || remaining[k] <= remaining[pick]))
                    begin
                        pick = k;
                        found = 1;
                    end
            end
            else if (policy == jsfsr_pkg::POL_RR)
            begin
                start = (cursor < count) ? cursor : 0;
                for (k = 0; k < count && !found; k++)
                begin
                    idx = start + k;
                    if (idx >= count)
                        idx -= count;
                    if (remaining[idx] != 0)
                    begin
                        pick = idx;
                        found = 1;
                    end
                end
            end
            else
            begin
                for (k = 0; k < count && !found; k++)
                    if (remaining[k] != 0)
                    begin
                        pick = k;
                        found = 1;
                    end
            end
            if (!found)
                done = 1;
            else
            begin
                run = remaining[pick];
                if (policy == jsfsr_pkg::POL_RR)
                begin
                    q = (quantum == 0) ? 16'd1 : quantum;
                    if (run > q)
                        run = q;
                    cursor = (pick + 1 < count) ? pick + 1 : 0;
                end
                remaining[pick] = remaining[pick] - run;
                sj = ids[pick];
                fin = (remaining[pick] == 0);
            end
        end
        else if (act == jsfsr_pkg::ACT_CLEAR)
        begin
            count = 0;
            cursor = 0;
        end
        pending_slices.push_back({5'd0, full, done, fin, run, sj});
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] exp;
        if (pending_slices.size() == 0)
        begin
            $error("result beat %h with nothing expected", got);
            errors++;
            return;
        end
        exp = pending_slices.pop_front();
        if (got[7:0] !== exp[7:0])
        begin
            $error("slice_job expected %0d got %0d", exp[7:0], got[7:0]);
            errors++;
        end
        if (got[23:8] !== exp[23:8])
        begin
            $error("slice_length expected %0d got %0d", exp[23:8], got[23:8]);
            errors++;
        end
        if (got[24] !== exp[24])
        begin
            $error("job_finished expected %0b got %0b", exp[24], got[24]);
            errors++;
        end
        if (got[25] !== exp[25])
        begin
            $error("schedule_done expected %0b got %0b", exp[25], got[25]);
            errors++;
        end
        if (got[26] !== exp[26])
        begin
            $error("table_full expected %0b got %0b", exp[26], got[26]);
            errors++;
        end
    endfunction
endclass

module testbench;
    import jsfsr_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    // [1:0] action
    logic [1:0]  s_axis_tuser = 0;
    // [7:0] job_id, [23:8] burst_time, [39:24] arrival_order
    logic [39:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    // [7:0] slice_job, [23:8] slice_length, [24] job_finished,
    // [25] schedule_done, [26] table_full
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    // While set, the result side refuses every beat so the block backs up.
    bit          hold_results = 0;
    slice_scoreboard slices;

    always #5 clk = ~clk;

    job_scheduler_fifo_sjf_rr_unit dut (.*);

    // Short gaps are the rule; now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, checked at the edge where a beat is taken.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                slices.check_result(m_axis_tdata);
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 0;
            end
            else if (hold_results)
                m_axis_tready <= 0;
            else
            begin
                stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // Offers one beat and waits for the handshake; the scoreboard notes it then.
    // Valid stays high after the handshake so beats can follow back to back;
    // it drops at the start of a gap or when the sender goes idle.
    task automatic send_beat(logic [1:0] act, logic [7:0] id, logic [15:0] burst,
                             logic [15:0] order);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {order, burst, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        slices.note_beat(act, {order, burst, id});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (slices.pending_slices.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Registers are written only once the block has drained.
    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        wait_idle();
        cfg_we <= 1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        slices.write_reg(index, value);
    endtask

    // Random beat: mostly inserts and next requests, with the odd clear or unused action.
    task automatic random_beat(int order_span);
        int r;
        logic [15:0] burst;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            case ($urandom_range(0, 5))
                0: burst = 0;
                1: burst = 16'hFFFF;
                2: burst = $urandom;
                default: burst = $urandom_range(1, 20);
            endcase
            send_beat(ACT_INSERT, $urandom, burst, $urandom_range(0, order_span));
        end
        else if (r < 95)
            send_beat(ACT_NEXT, $urandom, $urandom, $urandom);
        else if (r < 98)
            send_beat(ACT_CLEAR, $urandom, $urandom, $urandom);
        else
            send_beat(2'd3, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int i;
        int p;
        slices = new();
        slices.reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, equal orders, zero burst, full table, odd actions.
        send_beat(ACT_NEXT, 0, 0, 0);
        send_beat(ACT_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_INSERT, 8'h00, 16'd0, 16'd0);
        send_beat(ACT_INSERT, 8'h5A, 16'd3, 16'hFFFF);
        send_beat(ACT_INSERT, 8'hA5, 16'd3, 16'd7);
        send_beat(ACT_NEXT, 0, 0, 0);
        send_beat(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF);
        for (i = 0; i < 13; i++)
            send_beat(ACT_INSERT, i, 16'd1 + i, 16'd100);
        send_beat(ACT_INSERT, 8'h77, 16'd9, 16'd1);
        send_beat(ACT_NEXT, 0, 0, 0);
        send_beat(ACT_CLEAR, 0, 0, 0);
        send_beat(ACT_NEXT, 0, 0, 0);

        // Round robin with a zero quantum.
        write_reg(REG_POLICY, POL_RR);
        write_reg(REG_QUANTUM, 16'd0);
        for (i = 0; i < 4; i++)
            send_beat(ACT_INSERT, i, 16'd2, 16'd5);
        for (i = 0; i < 10; i++)
            send_beat(ACT_NEXT, 0, 0, 0);

        // The sender pauses here until every expected result is back.
        wait_idle();

        // Long receiver hold while the sender keeps offering beats.
        hold_results = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_results = 0;
            end
            for (i = 0; i < 6; i++)
                random_beat(20);
        join

        // Random phases through every policy and several quanta.
        for (p = 0; p < 12; p++)
        begin
            write_reg(REG_POLICY, (p == 11) ? 2'd3 : p % 3);
            case (p % 4)
                0: write_reg(REG_QUANTUM, 16'd1);
                1: write_reg(REG_QUANTUM, 16'hFFFF);
                2: write_reg(REG_QUANTUM, $urandom_range(2, 8));
                default: write_reg(REG_QUANTUM, $urandom);
            endcase
            for (i = 0; i < 140; i++)
                random_beat((p % 2) ? 16'hFFFF : 8);
        end

        wait_idle();
        if (slices.errors == 0 && slices.pending_slices.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
